### rtl/core/hex_record_parser_unit_assert.svh
// Assertion macros shared by the hex record parser RTL.
`ifndef HEX_RECORD_PARSER_UNIT_ASSERT_SVH
`define HEX_RECORD_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hrp_pkg.sv
// Types, codes and helper functions of the hex record parser.
package hrp_pkg;

    typedef enum logic [8:0] {
        PH_MARK = 9'b000000001,
        PH_LEN  = 9'b000000010,
        PH_OFF  = 9'b000000100,
        PH_TYPE = 9'b000001000,
        PH_DATA = 9'b000010000,
        PH_SUM  = 9'b000100000,
        PH_END  = 9'b001000000,
        PH_LF   = 9'b010000000,
        PH_DONE = 9'b100000000
    } t_phase;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_MARK   = 3'd0;
    localparam logic [2:0] ERR_LENGTH = 3'd1;
    localparam logic [2:0] ERR_OFFSET = 3'd2;
    localparam logic [2:0] ERR_TYPE   = 3'd3;
    localparam logic [2:0] ERR_DATA   = 3'd4;
    localparam logic [2:0] ERR_SUM    = 3'd5;
    localparam logic [2:0] ERR_END    = 3'd6;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [7:0] EOF_TYPE   = 8'h01;
    localparam int unsigned COL_BITS  = 10;
    localparam logic [COL_BITS-1:0] COL_LEN    = 10'd2;
    localparam logic [COL_BITS-1:0] COL_TYPE   = 10'd8;
    localparam logic [COL_BITS-1:0] COL_SUM0   = 10'd10;

    localparam int unsigned TDATA_BITS = 80;

    // {invalid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

### rtl/core/hex_record_parser_unit.sv
// Hex record parser: walks text records one character per transaction.
//
// One character is taken per clock cycle, back to back, while the sink
// accepts results, and each character yields at most one result (input
// register, then record-state update into the output register). The
// rate is set by the state update; while a result waits for the sink, the
// input register can still take one character. Results carry a kind in
// tuser: data byte, record complete with good checksum, or error. After
// the first error, or after an end-of-file record, characters are still
// taken but yield nothing until reset. type_limit is written through the
// cfg channel, by the user only while the block is idle (not enforced).
`include "hex_record_parser_unit_assert.svh"

module hex_record_parser_unit #(
    parameter int LINE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: type_limit
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] character
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] data_value, [15:8] byte_index, [31:16] load_offset,
    // [39:32] record_type, [47:40] record_length, [50:48] error_code,
    // [66:51] line_number, [76:67] column_number, [79:77] zero
    output logic [hrp_pkg::TDATA_BITS-1:0] o_m_tdata,
    output logic [1:0]  o_m_tuser    // [1:0] kind
);

    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
    localparam logic [hrp_pkg::COL_BITS-1:0] COL_TOP = '1;

    logic [7:0]                    r_type_limit;
    logic                          r_in_valid;
    logic [7:0]                    r_in_char;

    hrp_pkg::t_phase               r_phase, n_phase;
    logic [2:0]                    r_digit, n_digit;
    logic [3:0]                    r_high, n_high;
    logic [7:0]                    r_length, n_length;
    logic [15:0]                   r_offset, n_offset;
    logic [7:0]                    r_type, n_type;
    logic [7:0]                    r_sum, n_sum;
    logic [7:0]                    r_data_count, n_data_count;
    logic [LINE_BITS-1:0]          r_line, n_line;
    logic [hrp_pkg::COL_BITS-1:0]  r_column, n_column;
    logic                          r_halted, n_halted;

    logic                          r_out_valid;
    logic [1:0]                    r_out_kind;
    logic [hrp_pkg::TDATA_BITS-1:0] r_out_data;

    logic                          proc_ready;
    logic                          proc_fire;
    logic [4:0]                    hx;
    logic                          h_bad;
    logic [3:0]                    h;
    logic [7:0]                    byte_v;
    logic [15:0]                   off_shift;
    logic [hrp_pkg::COL_BITS-1:0]  pos_inc;
    logic [LINE_BITS-1:0]          ln_full;
    logic [LINE_BITS+15:0]         ln_ext;
    logic [15:0]                   ln_out;

    logic                          e_emit;
    logic [1:0]                    e_kind;
    logic [7:0]                    e_value;
    logic [7:0]                    e_idx;
    logic [2:0]                    e_code;
    logic [hrp_pkg::COL_BITS-1:0]  e_col;

    assign o_cfg_ready = 1'b1;
    assign proc_ready  = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || proc_ready;
    assign proc_fire   = r_in_valid && proc_ready;

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_kind;

    assign hx        = hrp_pkg::hex_decode(r_in_char);
    assign h_bad     = hx[4];
    assign h         = hx[3:0];
    assign byte_v    = {r_high, h};
    assign off_shift = {r_offset[11:0], h};
    assign pos_inc   = (r_column == COL_TOP) ? r_column : r_column + 1'b1;

    // 1-based line of the current record, clamped to 16 bits
    assign ln_full = (r_line == LINE_TOP) ? r_line : r_line + 1'b1;
    assign ln_ext  = {16'b0, ln_full};
    assign ln_out  = (ln_ext[LINE_BITS+15:16] != '0) ? 16'hFFFF : ln_ext[15:0];

    always_comb begin
        n_phase      = r_phase;
        n_digit      = r_digit;
        n_high       = r_high;
        n_length     = r_length;
        n_offset     = r_offset;
        n_type       = r_type;
        n_sum        = r_sum;
        n_data_count = r_data_count;
        n_line       = r_line;
        n_column     = r_column;
        n_halted     = r_halted;
        e_emit       = 1'b0;
        e_kind       = hrp_pkg::KIND_ERROR;
        e_value      = 8'd0;
        e_idx        = 8'd0;
        e_code       = hrp_pkg::ERR_MARK;
        e_col        = '0;

        if (!r_halted && r_phase != hrp_pkg::PH_DONE) begin
            n_column = pos_inc;
            case (r_phase)
                hrp_pkg::PH_MARK: begin
                    if (r_in_char != hrp_pkg::CHAR_COLON) begin
                        e_emit = 1'b1;
                        e_code = hrp_pkg::ERR_MARK;
                        e_col  = pos_inc;
                    end else begin
                        n_digit      = '0;
                        n_high       = '0;
                        n_length     = '0;
                        n_offset     = '0;
                        n_type       = '0;
                        n_sum        = '0;
                        n_data_count = '0;
                        n_phase      = hrp_pkg::PH_LEN;
                    end
                end
                hrp_pkg::PH_LEN: begin
                    if (h_bad) begin
                        e_emit = 1'b1;
                        e_code = hrp_pkg::ERR_LENGTH;
                        e_col  = hrp_pkg::COL_LEN;
                    end else if (r_digit == '0) begin
                        n_high  = h;
                        n_digit = 3'd1;
                    end else begin
                        n_length = byte_v;
                        n_sum    = r_sum + byte_v;
                        n_digit  = '0;
                        n_phase  = hrp_pkg::PH_OFF;
                    end
                end
                hrp_pkg::PH_OFF: begin
                    if (h_bad) begin
                        e_emit = 1'b1;
                        e_code = hrp_pkg::ERR_OFFSET;
                        e_col  = pos_inc;
                    end else begin
                        n_offset = off_shift;
                        n_digit  = r_digit + 1'b1;
                        if (r_digit == 3'd3) begin
                            n_sum   = r_sum + off_shift[15:8] + off_shift[7:0];
                            n_digit = '0;
                            n_phase = hrp_pkg::PH_TYPE;
                        end
                    end
                end
                hrp_pkg::PH_TYPE: begin
                    if (h_bad) begin
                        e_emit = 1'b1;
                        e_code = hrp_pkg::ERR_TYPE;
                        e_col  = hrp_pkg::COL_TYPE;
                    end else if (r_digit == '0) begin
                        n_high  = h;
                        n_digit = 3'd1;
                    end else begin
                        n_type  = byte_v;
                        n_digit = '0;
                        if (byte_v >= r_type_limit) begin
                            e_emit = 1'b1;
                            e_code = hrp_pkg::ERR_TYPE;
                            e_col  = hrp_pkg::COL_TYPE;
                        end else begin
                            n_sum   = r_sum + byte_v;
                            n_phase = (r_length == '0) ? hrp_pkg::PH_SUM : hrp_pkg::PH_DATA;
                        end
                    end
                end
                hrp_pkg::PH_DATA: begin
                    if (h_bad) begin
                        e_emit = 1'b1;
                        e_code = hrp_pkg::ERR_DATA;
                        e_col  = pos_inc;
                    end else if (r_digit == '0) begin
                        n_high  = h;
                        n_digit = 3'd1;
                    end else begin
                        n_digit      = '0;
                        n_sum        = r_sum + byte_v;
                        e_emit       = 1'b1;
                        e_kind       = hrp_pkg::KIND_DATA;
                        e_value      = byte_v;
                        e_idx        = r_data_count;
                        n_data_count = r_data_count + 1'b1;
                        if (n_data_count >= r_length) begin
                            n_phase = hrp_pkg::PH_SUM;
                        end
                    end
                end
                hrp_pkg::PH_SUM: begin
                    if (h_bad) begin
                        e_emit = 1'b1;
                        e_code = hrp_pkg::ERR_SUM;
                        e_col  = pos_inc;
                    end else if (r_digit == '0) begin
                        n_high  = h;
                        n_digit = 3'd1;
                    end else begin
                        n_digit = '0;
                        e_emit  = 1'b1;
                        if (8'(r_sum + byte_v) != 8'd0) begin
                            e_code = hrp_pkg::ERR_SUM;
                            e_col  = hrp_pkg::COL_SUM0 + {1'b0, r_length, 1'b0};
                        end else begin
                            e_kind  = hrp_pkg::KIND_RECORD;
                            n_phase = (r_type == hrp_pkg::EOF_TYPE) ? hrp_pkg::PH_DONE
                                                                     : hrp_pkg::PH_END;
                        end
                    end
                end
                hrp_pkg::PH_END: begin
                    if (r_in_char == hrp_pkg::CHAR_CR) begin
                        n_phase = hrp_pkg::PH_LF;
                    end else if (r_in_char != hrp_pkg::CHAR_LF) begin
                        e_emit = 1'b1;
                        e_code = hrp_pkg::ERR_END;
                        e_col  = pos_inc;
                    end else begin
                        n_line   = (r_line == LINE_TOP) ? r_line : r_line + 1'b1;
                        n_column = '0;
                        n_phase  = hrp_pkg::PH_MARK;
                    end
                end
                hrp_pkg::PH_LF: begin
                    // report at the column of the lone CR
                    if (r_in_char != hrp_pkg::CHAR_LF) begin
                        e_emit = 1'b1;
                        e_code = hrp_pkg::ERR_END;
                        e_col  = r_column;
                    end else begin
                        n_line   = (r_line == LINE_TOP) ? r_line : r_line + 1'b1;
                        n_column = '0;
                        n_phase  = hrp_pkg::PH_MARK;
                    end
                end
                default: begin
                    n_column = r_column;
                end
            endcase
            if (e_emit && e_kind == hrp_pkg::KIND_ERROR) begin
                n_halted = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_limit <= 8'd6;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= hrp_pkg::PH_MARK;
            r_digit      <= '0;
            r_high       <= '0;
            r_length     <= '0;
            r_offset     <= '0;
            r_type       <= '0;
            r_sum        <= '0;
            r_data_count <= '0;
            r_line       <= '0;
            r_column     <= '0;
            r_halted     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_type_limit <= i_cfg_data;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (proc_ready) begin
                r_out_valid <= proc_fire && e_emit;
            end
            if (proc_fire) begin
                r_phase      <= n_phase;
                r_digit      <= n_digit;
                r_high       <= n_high;
                r_length     <= n_length;
                r_offset     <= n_offset;
                r_type       <= n_type;
                r_sum        <= n_sum;
                r_data_count <= n_data_count;
                r_line       <= n_line;
                r_column     <= n_column;
                r_halted     <= n_halted;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_tdata;
        end
        if (proc_fire && e_emit) begin
            r_out_kind <= e_kind;
            r_out_data <= {3'b000, e_col, ln_out, e_code, n_length, n_type, n_offset,
                           e_idx, e_value};
        end
    end

    `HRP_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halted, r_halted,
                     "halt flag cleared without reset")
    `HRP_ASSERT_NEXT(a_error_halts, i_clk, i_rst_n,
                     proc_fire && e_emit && e_kind == hrp_pkg::KIND_ERROR, r_halted,
                     "error result did not halt the parser")
    `HRP_ASSERT_NOW(a_quiet_when_stopped, i_clk, i_rst_n,
                    proc_fire && (r_halted || r_phase == hrp_pkg::PH_DONE), !e_emit,
                    "result produced after halt or end-of-file record")
    `HRP_ASSERT_NOW(a_mark_at_col0, i_clk, i_rst_n,
                    r_phase == hrp_pkg::PH_MARK && !r_halted, r_column == '0,
                    "record mark expected away from line start")
    `HRP_ASSERT_NOW(a_data_in_range, i_clk, i_rst_n,
                    r_phase == hrp_pkg::PH_DATA, r_data_count < r_length,
                    "data index reached record length in data phase")

endmodule
